// File: rtl/core/rau_pkg.sv
// ----------------------------------------------------------------------------
// rau_pkg
// types, codes and controller/datapath interface for the rational arithmetic
// unit
// ----------------------------------------------------------------------------
package rau_pkg;

	typedef enum logic [3:0] {
		OP_NORM   = 4'd0,
		OP_ADD    = 4'd1,
		OP_SUB    = 4'd2,
		OP_MUL    = 4'd3,
		OP_DIV    = 4'd4,
		OP_EQ     = 4'd5,
		OP_LT     = 4'd6,
		OP_LE     = 4'd7,
		OP_GT     = 4'd8,
		OP_GE     = 4'd9,
		OP_TO_INT = 4'd10
	} opcode_t;

	localparam logic [1:0] KIND_FINITE = 2'd0;
	localparam logic [1:0] KIND_MAX    = 2'd1;
	localparam logic [1:0] KIND_MIN    = 2'd2;

	typedef struct packed {
		logic [3:0]         opcode;
		logic signed [31:0] a_num;
		logic signed [31:0] a_den;
		logic [1:0]         a_kind;
		logic signed [31:0] b_num;
		logic signed [31:0] b_den;
		logic [1:0]         b_kind;
	} req_t;

	typedef struct packed {
		logic signed [31:0] res_num;
		logic [30:0]        res_den;
		logic [1:0]         res_kind;
		logic               compare_true;
		logic               overflow;
	} rsp_t;

	typedef enum logic [1:0] {
		MUL_NONE,
		MUL_P1,
		MUL_P2,
		MUL_P3
	} mul_sel_t;

	typedef enum logic [1:0] {
		DIV_NUM,
		DIV_DEN,
		DIV_TOINT
	} div_sel_t;

	typedef enum logic [2:0] {
		RES_HOLD,
		RES_DIRECT,
		RES_CMP,
		RES_EMIT,
		RES_TOINT
	} res_sel_t;

	typedef struct packed {
		logic     load;
		mul_sel_t mul_sel;
		logic     combine;
		logic     gcd_step;
		logic     div_init;
		div_sel_t div_sel;
		logic     div_step;
		logic     take_n;
		res_sel_t res_sel;
	} cmd_t;

	typedef struct packed {
		logic direct;
		logic is_cmp;
		logic is_toint;
		logic gcd_done;
	} status_t;

endpackage

// File: rtl/core/rational_arithmetic_unit.sv
// ----------------------------------------------------------------------------
// rational_arithmetic_unit
// exact rational add, subtract, multiply, divide, compare and truncate with
// gcd reduction of every arithmetic result
// ----------------------------------------------------------------------------
// req carries an opcode and two rationals (numerator, denominator, kind);
// rsp carries one result per transaction. Both channels use valid/stall.
// One transaction is worked on at a time: req_stall stays high from the
// accepting edge until the result has been taken on rsp; the next
// transaction can be accepted in the cycle after the result is taken.
// Comparisons, sentinel and zero-denominator cases go from dispatch straight
// to rsp_valid. A to_int of a finite value makes one 64-step restoring
// division. Arithmetic on finite values runs the binary gcd, one step per
// cycle, then two 64-step quotient passes through the shared divider.
// A 32x32 multiplier forms the cross products one after another.
// Reset clears the sequencer; the block then takes a transaction at once.
// While rsp_stall is high the result is held unchanged on rsp and no new
// transaction is accepted.
// ----------------------------------------------------------------------------
module rational_arithmetic_unit #(
	parameter int WIDTH = 32
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_stall,
	input  rau_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	output rau_pkg::rsp_t rsp
);
	import rau_pkg::*;

	cmd_t    cmd;
	status_t st;

	rau_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.cmd       (cmd),
		.st        (st)
	);

	rau_dp #(
		.WIDTH (WIDTH)
	) u_dp (
		.clk (clk),
		.req (req),
		.cmd (cmd),
		.st  (st),
		.rsp (rsp)
	);

endmodule

// File: rtl/core/rau_ctrl.sv
// ----------------------------------------------------------------------------
// rau_ctrl
// sequencer: operand products, gcd reduction, quotient passes and handshakes
// ----------------------------------------------------------------------------
module rau_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             req_valid,
	output logic             req_stall,
	output logic             rsp_valid,
	input  logic             rsp_stall,
	output rau_pkg::cmd_t    cmd,
	input  rau_pkg::status_t st
);
	import rau_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE,
		S_MUL1,
		S_MUL2,
		S_MUL3,
		S_DISPATCH,
		S_COMBINE,
		S_GCD,
		S_INITN,
		S_DIVN,
		S_INITD,
		S_DIVD,
		S_EMIT,
		S_INITQ,
		S_DIVQ,
		S_TOINT,
		S_OUT
	} state_t;

	state_t     state_q;
	logic [5:0] cnt_q;
	logic       accept;
	logic       last;

	assign accept = req_valid && !req_stall;
	assign last   = &cnt_q;

	always_comb begin
		cmd = '0;
		cmd.mul_sel = MUL_NONE;
		cmd.div_sel = DIV_NUM;
		cmd.res_sel = RES_HOLD;
		cmd.load    = accept;
		case (state_q)
			S_MUL1: cmd.mul_sel = MUL_P1;
			S_MUL2: cmd.mul_sel = MUL_P2;
			S_MUL3: cmd.mul_sel = MUL_P3;
			S_DISPATCH: begin
				if (st.direct) begin
					cmd.res_sel = RES_DIRECT;
				end else if (st.is_cmp) begin
					cmd.res_sel = RES_CMP;
				end
			end
			S_COMBINE: cmd.combine = 1'b1;
			S_GCD: cmd.gcd_step = !st.gcd_done;
			S_INITN: begin
				cmd.div_init = 1'b1;
				cmd.div_sel  = DIV_NUM;
			end
			S_INITD: begin
				cmd.div_init = 1'b1;
				cmd.div_sel  = DIV_DEN;
				cmd.take_n   = 1'b1;
			end
			S_INITQ: begin
				cmd.div_init = 1'b1;
				cmd.div_sel  = DIV_TOINT;
			end
			S_DIVN, S_DIVD, S_DIVQ: cmd.div_step = 1'b1;
			S_EMIT: cmd.res_sel = RES_EMIT;
			S_TOINT: cmd.res_sel = RES_TOINT;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			cnt_q     <= '0;
			req_stall <= 1'b0;
			rsp_valid <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q   <= S_MUL1;
						req_stall <= 1'b1;
					end
				end
				S_MUL1: state_q <= S_MUL2;
				S_MUL2: state_q <= S_MUL3;
				S_MUL3: state_q <= S_DISPATCH;
				S_DISPATCH: begin
					if (st.direct || st.is_cmp) begin
						state_q   <= S_OUT;
						rsp_valid <= 1'b1;
					end else if (st.is_toint) begin
						state_q <= S_INITQ;
					end else begin
						state_q <= S_COMBINE;
					end
				end
				S_COMBINE: state_q <= S_GCD;
				S_GCD: begin
					if (st.gcd_done) begin
						state_q <= S_INITN;
					end
				end
				S_INITN, S_INITD, S_INITQ: begin
					cnt_q <= '0;
					state_q <= (state_q == S_INITN) ? S_DIVN :
						(state_q == S_INITD) ? S_DIVD : S_DIVQ;
				end
				S_DIVN, S_DIVD, S_DIVQ: begin
					cnt_q <= cnt_q + 6'd1;
					if (last) begin
						state_q <= (state_q == S_DIVN) ? S_INITD :
							(state_q == S_DIVD) ? S_EMIT : S_TOINT;
					end
				end
				S_EMIT, S_TOINT: begin
					state_q   <= S_OUT;
					rsp_valid <= 1'b1;
				end
				S_OUT: begin
					if (!rsp_stall) begin
						state_q   <= S_IDLE;
						rsp_valid <= 1'b0;
						req_stall <= 1'b0;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

// File: rtl/core/rau_dp.sv
// ----------------------------------------------------------------------------
// rau_dp
// datapath: operand registers, shared multiplier, binary gcd, restoring
// divider and result formatting
// ----------------------------------------------------------------------------
module rau_dp #(
	parameter int WIDTH = 32
) (
	input  logic             clk,
	input  rau_pkg::req_t    req,
	input  rau_pkg::cmd_t    cmd,
	output rau_pkg::status_t st,
	output rau_pkg::rsp_t    rsp
);
	import rau_pkg::*;

	localparam logic [63:0] LIM = (64'd1 << (WIDTH - 1)) - 64'd1;

	typedef struct packed {
		logic [1:0]  kind;
		logic        neg;
		logic [31:0] n;
		logic [31:0] d;
	} opnd_t;

	opcode_t     op_q;
	opnd_t       a_q, b_q;
	logic [63:0] p1_q, p2_q, p3_q;
	logic [63:0] rn_q, rd_q;
	logic        rneg_q;
	logic [63:0] gx_q, gy_q;
	logic [5:0]  gk_q;
	logic [63:0] quo_q, dv_q;
	logic [64:0] rem_q;
	rsp_t        rsp_q;

	function automatic opnd_t load_op(input logic [31:0] num, input logic [31:0] den,
			input logic [1:0] kind);
		opnd_t r;
		r.kind = (kind == KIND_MAX || kind == KIND_MIN) ? kind : KIND_FINITE;
		r.neg  = num[31] ^ den[31];
		r.n    = num[31] ? (~num + 32'd1) : num;
		r.d    = den[31] ? (~den + 32'd1) : den;
		if (r.kind != KIND_FINITE) begin
			r.neg = 1'b0;
			r.n   = '0;
			r.d   = '0;
		end else if (r.d == '0) begin
			r.neg = 1'b0;
			r.n   = {31'd0, (r.n != '0)};
		end else if (r.n == '0) begin
			r.neg = 1'b0;
		end
		return r;
	endfunction

	function automatic rsp_t spec(input opnd_t o);
		rsp_t r;
		r = '0;
		if (o.kind != KIND_FINITE) begin
			r.res_kind = o.kind;
		end else if (o.d == '0) begin
			r.res_num = o.n;
		end else begin
			r.res_den = 31'd1;
		end
		return r;
	endfunction

	function automatic rsp_t emit(input logic neg, input logic [63:0] n,
			input logic [63:0] d);
		rsp_t        r;
		logic [31:0] nl;
		r = '0;
		nl = n[31:0];
		if ((neg ? (n > LIM + 64'd1) : (n > LIM)) || d > LIM) begin
			r.overflow = 1'b1;
		end else begin
			r.res_num = neg ? (~nl + 32'd1) : nl;
			r.res_den = d[30:0];
		end
		return r;
	endfunction

	// operand products on the shared multiplier
	logic [31:0] mx, my;
	always_comb begin
		mx = a_q.n;
		my = b_q.d;
		case (cmd.mul_sel)
			MUL_P1: begin
				mx = a_q.n;
				my = (op_q == OP_MUL) ? b_q.n : b_q.d;
			end
			MUL_P2: begin
				mx = b_q.n;
				my = a_q.d;
			end
			MUL_P3: begin
				mx = a_q.d;
				my = (op_q == OP_DIV) ? b_q.n : b_q.d;
			end
			default: ;
		endcase
	end

	// special operands and direct results
	logic asp, bsp, bsp_div;
	rsp_t direct_r;
	always_comb begin
		asp     = (a_q.kind != KIND_FINITE) || (a_q.d == '0);
		bsp     = (b_q.kind != KIND_FINITE) || (b_q.d == '0);
		bsp_div = (b_q.kind != KIND_FINITE) || (b_q.n == '0);
		st.direct   = 1'b0;
		st.is_cmp   = 1'b0;
		st.is_toint = 1'b0;
		st.gcd_done = (gx_q == '0);
		direct_r    = '0;
		case (op_q)
			OP_NORM: begin
				st.direct = asp;
				direct_r  = spec(a_q);
			end
			OP_ADD, OP_SUB, OP_MUL: begin
				st.direct = asp || bsp;
				direct_r  = asp ? spec(a_q) : spec(b_q);
			end
			OP_DIV: begin
				st.direct = asp || bsp_div;
				direct_r  = asp ? spec(a_q) : spec(b_q);
			end
			OP_EQ, OP_LT, OP_LE, OP_GT, OP_GE: st.is_cmp = 1'b1;
			OP_TO_INT: begin
				st.is_toint = 1'b1;
				if (a_q.kind != KIND_FINITE) begin
					st.direct        = 1'b1;
					direct_r.res_den = 31'd1;
				end else if (a_q.d == '0) begin
					st.direct = 1'b1;
					if (a_q.n != '0) begin
						direct_r.res_num  = LIM[31:0];
						direct_r.res_kind = KIND_MAX;
					end else begin
						direct_r.res_num  = ~LIM[31:0];
						direct_r.res_kind = KIND_MIN;
					end
				end
			end
			default: st.direct = 1'b1;
		endcase
	end

	// comparison outcome
	logic signed [63:0] ps, qs;
	logic               less_side, cmp_r;
	always_comb begin
		ps = a_q.neg ? -$signed(p1_q) : $signed(p1_q);
		qs = b_q.neg ? -$signed(p2_q) : $signed(p2_q);
		less_side = (op_q == OP_LT) || (op_q == OP_LE);
		cmp_r = 1'b0;
		if (op_q == OP_EQ) begin
			cmp_r = (a_q.kind == b_q.kind) && ((a_q.kind != KIND_FINITE) ||
				(((a_q.d == '0) == (b_q.d == '0)) &&
				((a_q.d == '0) ? (a_q.n == b_q.n) : (ps == qs))));
		end else if (a_q.kind == KIND_MIN || b_q.kind == KIND_MAX) begin
			cmp_r = less_side;
		end else if (a_q.kind == KIND_MAX || b_q.kind == KIND_MIN) begin
			cmp_r = !less_side;
		end else begin
			case (op_q)
				OP_LT: cmp_r = ps < qs;
				OP_LE: cmp_r = ps <= qs;
				OP_GT: cmp_r = ps > qs;
				default: cmp_r = ps >= qs;
			endcase
		end
	end

	// unreduced result of the arithmetic
	logic [63:0] cn, cd;
	logic        cneg, s2;
	always_comb begin
		s2   = b_q.neg ^ (op_q == OP_SUB);
		cn   = p1_q;
		cd   = p3_q;
		cneg = a_q.neg ^ b_q.neg;
		case (op_q)
			OP_NORM: begin
				cn   = {32'd0, a_q.n};
				cd   = {32'd0, a_q.d};
				cneg = a_q.neg;
			end
			OP_ADD, OP_SUB: begin
				if (a_q.neg == s2) begin
					cn   = p1_q + p2_q;
					cneg = a_q.neg;
				end else if (p1_q >= p2_q) begin
					cn   = p1_q - p2_q;
					cneg = a_q.neg;
				end else begin
					cn   = p2_q - p1_q;
					cneg = s2;
				end
			end
			default: ;
		endcase
	end

	logic [64:0] rem_sh;
	logic        q_bit;
	assign rem_sh = {rem_q[63:0], quo_q[63]};
	assign q_bit  = rem_sh >= {1'b0, dv_q};

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q <= opcode_t'(req.opcode);
			a_q  <= load_op(req.a_num, req.a_den, req.a_kind);
			b_q  <= load_op(req.b_num, req.b_den, req.b_kind);
		end
		case (cmd.mul_sel)
			MUL_P1: p1_q <= {32'd0, mx} * {32'd0, my};
			MUL_P2: p2_q <= {32'd0, mx} * {32'd0, my};
			MUL_P3: p3_q <= {32'd0, mx} * {32'd0, my};
			default: ;
		endcase
		if (cmd.combine) begin
			rn_q   <= cn;
			rd_q   <= cd;
			rneg_q <= cneg && (cn != '0);
			gx_q   <= cn;
			gy_q   <= cd;
			gk_q   <= '0;
		end
		if (cmd.gcd_step) begin
			if (!gx_q[0] && !gy_q[0]) begin
				gx_q <= gx_q >> 1;
				gy_q <= gy_q >> 1;
				gk_q <= gk_q + 6'd1;
			end else if (!gx_q[0]) begin
				gx_q <= gx_q >> 1;
			end else if (!gy_q[0]) begin
				gy_q <= gy_q >> 1;
			end else if (gx_q >= gy_q) begin
				gx_q <= gx_q - gy_q;
			end else begin
				gy_q <= gy_q - gx_q;
			end
		end
		if (cmd.take_n) begin
			rn_q <= quo_q;
		end
		if (cmd.div_init) begin
			rem_q <= '0;
			case (cmd.div_sel)
				DIV_NUM: begin
					quo_q <= rn_q;
					dv_q  <= gy_q << gk_q;
				end
				DIV_DEN: begin
					quo_q <= rd_q;
					dv_q  <= gy_q << gk_q;
				end
				default: begin
					quo_q <= {32'd0, a_q.n};
					dv_q  <= {32'd0, a_q.d};
				end
			endcase
		end else if (cmd.div_step) begin
			rem_q <= q_bit ? (rem_sh - {1'b0, dv_q}) : rem_sh;
			quo_q <= {quo_q[62:0], q_bit};
		end
		case (cmd.res_sel)
			RES_DIRECT: rsp_q <= direct_r;
			RES_CMP: rsp_q <= rsp_t'({65'd0, cmp_r, 1'b0});
			RES_EMIT: rsp_q <= emit(rneg_q, rn_q, quo_q);
			RES_TOINT: rsp_q <= emit(a_q.neg && (quo_q != '0), quo_q, 64'd1);
			default: ;
		endcase
	end

	assign rsp = rsp_q;

endmodule

// File: rtl/core/rau_checker.sv
// ----------------------------------------------------------------------------
// rau_checker
// port-level checks on transaction ordering and result coding
// ----------------------------------------------------------------------------
module rau_checker (
	input logic          clk,
	input logic          arst_n,
	input logic          req_valid,
	input logic          req_stall,
	input rau_pkg::req_t req,
	input logic          rsp_valid,
	input logic          rsp_stall,
	input rau_pkg::rsp_t rsp
);
	import rau_pkg::*;

	// one transaction in flight
	a_busy_while_rsp: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> req_stall)
		else $error("request taken while a result waits");

	a_stall_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && !req_stall) |=> (req_stall && !rsp_valid))
		else $error("no busy cycle after accepting a transaction");

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp)))
		else $error("stalled result changed");

	a_ovf_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp.overflow) |-> (rsp.res_num == '0 && rsp.res_den == '0 &&
		rsp.res_kind == KIND_FINITE && !rsp.compare_true))
		else $error("overflow result not cleared");

	a_cmp_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp.compare_true) |-> (rsp.res_num == '0 && rsp.res_den == '0 &&
		rsp.res_kind == KIND_FINITE))
		else $error("comparison result carries a value");

endmodule

bind rational_arithmetic_unit rau_checker u_rau_checker (.*);

// File: tb/sv/rational_arithmetic_unit_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rational_arithmetic_unit_tb
// self-checking bench for the rational arithmetic unit: directed corner
// transactions then random traffic, predicted in a scoreboard class and
// compared field by field against every response
// ----------------------------------------------------------------------------
module rational_arithmetic_unit_tb;
	import rau_pkg::*;

	localparam int WIDTH = 32;
	localparam int NUM_RANDOM = 1250;
	localparam int CYCLE_LIMIT = 2000000;
	localparam int DRAIN_CYCLES = 300;

	typedef struct {
		int              kind;
		bit              neg;
		longint unsigned n;
		longint unsigned d;
	} fraction_t;

	class rau_scoreboard;
		rsp_t expected_rsp[$];
		int   errors;

		function new();
			errors = 0;
		endfunction

		task report(string msg);
			$display("mismatch at %0t: %s", $realtime, msg);
			errors++;
		endtask

		function longint unsigned gcd(longint unsigned x, longint unsigned y);
			longint unsigned t;
			while (y != 0) begin
				t = x % y;
				x = y;
				y = t;
			end
			return x;
		endfunction

		function fraction_t reduced(fraction_t r);
			longint unsigned g;
			if (r.kind != 0)
				return r;
			if (r.n == 0 && r.d == 0) begin
				r.neg = 0;
			end else if (r.d == 0) begin
				r.n = 1;
				r.neg = 0;
			end else if (r.n == 0) begin
				r.d = 1;
				r.neg = 0;
			end
			g = gcd(r.n, r.d);
			if (g != 0) begin
				r.n = r.n / g;
				r.d = r.d / g;
			end
			return r;
		endfunction

		function fraction_t load(logic signed [31:0] num, logic signed [31:0] den,
				logic [1:0] k);
			fraction_t r;
			longint sn, sd;
			sn = num;
			sd = den;
			r.kind = (k == KIND_MAX || k == KIND_MIN) ? int'(k) : 0;
			r.neg = (sn < 0) != (sd < 0);
			r.n = (sn < 0) ? -sn : sn;
			r.d = (sd < 0) ? -sd : sd;
			if (r.kind != 0) begin
				r.neg = 0;
				r.n = 0;
				r.d = 0;
			end
			return reduced(r);
		endfunction

		function rsp_t emit(fraction_t r);
			rsp_t o;
			longint unsigned lim;
			longint unsigned sv;
			o = '0;
			lim = (64'd1 << (WIDTH - 1)) - 1;
			if (r.kind != 0) begin
				o.res_kind = r.kind[1:0];
				return o;
			end
			if ((r.neg ? r.n > lim + 1 : r.n > lim) || r.d > lim) begin
				o.overflow = 1;
				return o;
			end
			sv = r.neg ? -r.n : r.n;
			o.res_num = sv[31:0];
			o.res_den = r.d[30:0];
			return o;
		endfunction

		function rsp_t predict_rsp(req_t q);
			rsp_t o;
			fraction_t a, b, r;
			longint unsigned g, t1, t2;
			longint p, pq;
			bit s2, less_side, do_sub, do_div;
			int rel;
			o = '0;
			a = load(q.a_num, q.a_den, q.a_kind);
			b = load(q.b_num, q.b_den, q.b_kind);
			case (q.opcode)
				OP_NORM: o = emit(a);
				OP_ADD, OP_SUB: begin
					do_sub = (q.opcode == OP_SUB);
					if (a.kind != 0 || a.d == 0) begin
						r = a;
					end else if (b.kind != 0 || b.d == 0) begin
						r = b;
					end else begin
						g = gcd(a.d, b.d);
						r.kind = 0;
						r.d = a.d / g * b.d;
						t1 = a.n * (b.d / g);
						t2 = b.n * (a.d / g);
						s2 = b.neg != do_sub;
						if (a.neg == s2) begin
							r.n = t1 + t2;
							r.neg = a.neg;
						end else if (t1 >= t2) begin
							r.n = t1 - t2;
							r.neg = a.neg;
						end else begin
							r.n = t2 - t1;
							r.neg = s2;
						end
						r = reduced(r);
					end
					o = emit(r);
				end
				OP_MUL, OP_DIV: begin
					do_div = (q.opcode == OP_DIV);
					if (a.kind != 0 || a.d == 0) begin
						r = a;
					end else if (b.kind != 0 || (do_div ? b.n == 0 : b.d == 0)) begin
						r = b;
					end else begin
						r.kind = 0;
						r.neg = a.neg != b.neg;
						r.n = do_div ? a.n * b.d : a.n * b.n;
						r.d = do_div ? a.d * b.n : a.d * b.d;
						r = reduced(r);
					end
					o = emit(r);
				end
				OP_EQ: o.compare_true = (a.kind == b.kind) && (a.kind != 0 ||
						(a.neg == b.neg && a.n == b.n && a.d == b.d));
				OP_LT, OP_LE, OP_GT, OP_GE: begin
					rel = int'(q.opcode) - int'(OP_LT);
					less_side = rel < 2;
					if (a.kind == 2 || b.kind == 1) begin
						o.compare_true = less_side;
					end else if (a.kind == 1 || b.kind == 2) begin
						o.compare_true = !less_side;
					end else begin
						p = (a.neg ? -longint'(a.n) : longint'(a.n)) * longint'(b.d);
						pq = longint'(a.d) * (b.neg ? -longint'(b.n) : longint'(b.n));
						case (rel)
							0: o.compare_true = p < pq;
							1: o.compare_true = p <= pq;
							2: o.compare_true = p > pq;
							default: o.compare_true = p >= pq;
						endcase
					end
				end
				OP_TO_INT: begin
					if (a.kind != 0) begin
						o.res_den = 1;
					end else if (a.d == 0) begin
						if (a.n != 0) begin
							o.res_num = 32'(((64'd1 << (WIDTH - 1)) - 1));
							o.res_kind = KIND_MAX;
						end else begin
							o.res_num = 32'(-(64'd1 << (WIDTH - 1)));
							o.res_kind = KIND_MIN;
						end
					end else begin
						r.kind = 0;
						r.neg = a.neg;
						r.n = a.n / a.d;
						r.d = 1;
						if (r.n == 0)
							r.neg = 0;
						o = emit(r);
					end
				end
				default: ;
			endcase
			return o;
		endfunction

		function void note_request(req_t q);
			expected_rsp.push_back(predict_rsp(q));
		endfunction

		task check_response(rsp_t got);
			rsp_t exp;
			if (expected_rsp.size() == 0) begin
				report("response with no transaction outstanding");
				return;
			end
			exp = expected_rsp.pop_front();
			if (got.res_num !== exp.res_num)
				report($sformatf("res_num %h, want %h", got.res_num, exp.res_num));
			if (got.res_den !== exp.res_den)
				report($sformatf("res_den %h, want %h", got.res_den, exp.res_den));
			if (got.res_kind !== exp.res_kind)
				report($sformatf("res_kind %0d, want %0d", got.res_kind, exp.res_kind));
			if (got.compare_true !== exp.compare_true)
				report($sformatf("compare_true %b, want %b", got.compare_true,
					exp.compare_true));
			if (got.overflow !== exp.overflow)
				report($sformatf("overflow %b, want %b", got.overflow, exp.overflow));
		endtask
	endclass

	logic  clk;
	logic  arst_n;
	logic  req_valid;
	logic  req_stall;
	req_t  req;
	logic  rsp_valid;
	logic  rsp_stall;
	rsp_t  rsp;

	rau_scoreboard sb = new();
	int unsigned   cycle_count = 0;
	int            burst_left;

	rational_arithmetic_unit #(.WIDTH(WIDTH)) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	initial clk = 0;
	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && rsp_valid && !rsp_stall)
			sb.check_response(rsp);
	end

	// receiver stall pattern, with one long hold-off to back the block up
	initial begin : receiver
		int mode;
		int n;
		rsp_stall <= 0;
		@(posedge arst_n);
		n = 0;
		mode = 0;
		forever begin
			@(posedge clk);
			n++;
			if (n % 200 == 0)
				mode = $urandom_range(0, 3);
			if (n >= 30000 && n < 32000)
				rsp_stall <= 1;
			else if (mode == 0)
				rsp_stall <= 0;
			else if (mode == 1)
				rsp_stall <= ($urandom_range(0, 3) == 0);
			else if (mode == 2)
				rsp_stall <= ($urandom_range(0, 9) < 7);
			else
				rsp_stall <= ($urandom_range(0, 1) == 0);
		end
	end

	function automatic req_t make_req(logic [3:0] op, logic [31:0] an, logic [31:0] ad,
			logic [1:0] ak, logic [31:0] bn, logic [31:0] bd, logic [1:0] bk);
		req_t r;
		r.opcode = op;
		r.a_num = an;
		r.a_den = ad;
		r.a_kind = ak;
		r.b_num = bn;
		r.b_den = bd;
		r.b_kind = bk;
		return r;
	endfunction

	function automatic logic [31:0] rand_value();
		case ($urandom_range(0, 5))
			0, 1: return 32'($signed($urandom_range(0, 40)) - 20);
			2: return $urandom();
			3: case ($urandom_range(0, 4))
				0: return 32'h8000_0000;
				1: return 32'h7fff_ffff;
				2: return 32'h0;
				3: return 32'h1;
				default: return 32'hffff_ffff;
			endcase
			4: return 32'($signed($urandom_range(0, 2000)) - 1000) * 32'($urandom_range(1, 60));
			default: return 32'($urandom_range(0, 65535)) - 32'd32768;
		endcase
	endfunction

	function automatic logic [1:0] rand_kind();
		if ($urandom_range(0, 9) < 8)
			return KIND_FINITE;
		return 2'($urandom_range(1, 3));
	endfunction

	function automatic req_t rand_req();
		logic [3:0] op;
		if ($urandom_range(0, 19) == 0)
			op = 4'($urandom_range(11, 15));
		else
			op = 4'($urandom_range(0, 10));
		return make_req(op, rand_value(), rand_value(), rand_kind(),
			rand_value(), rand_value(), rand_kind());
	endfunction

	// offer one transaction and hold it until accepted
	task drive_req(input req_t r);
		req <= r;
		req_valid <= 1;
		do @(posedge clk); while (req_stall);
		sb.note_request(r);
	endtask

	task offer(input req_t r);
		int gap;
		if (burst_left == 0) begin
			gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 15);
			if (gap > 0) begin
				req_valid <= 0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 20);
		end
		burst_left--;
		drive_req(r);
	endtask

	initial begin : stimulus
		req_t directed[$];
		int drain;
		arst_n <= 0;
		req_valid <= 0;
		req <= '0;
		burst_left = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		directed.push_back(make_req(OP_NORM, -6, -4, KIND_FINITE, 0, 0, KIND_FINITE));
		directed.push_back(make_req(OP_NORM, 0, 0, KIND_FINITE, 0, 0, KIND_FINITE));
		directed.push_back(make_req(OP_NORM, -5, 0, KIND_FINITE, 0, 0, KIND_FINITE));
		directed.push_back(make_req(OP_NORM, 0, -7, 2'd3, 0, 0, KIND_FINITE));
		directed.push_back(make_req(OP_NORM, 32'h8000_0000, 32'hffff_ffff, KIND_FINITE,
			0, 1, KIND_FINITE));
		directed.push_back(make_req(OP_ADD, 1, 2, KIND_FINITE, 1, 3, KIND_FINITE));
		directed.push_back(make_req(OP_ADD, 32'h7fff_ffff, 1, KIND_FINITE,
			32'h7fff_ffff, 1, KIND_FINITE));
		directed.push_back(make_req(OP_SUB, 1, 3, KIND_FINITE, 5, 0, KIND_FINITE));
		directed.push_back(make_req(OP_SUB, 3, 4, KIND_MAX, 1, 2, KIND_MIN));
		directed.push_back(make_req(OP_SUB, 1, 2, KIND_FINITE, 0, 0, KIND_MIN));
		directed.push_back(make_req(OP_MUL, 32'h8000_0000, 1, KIND_FINITE,
			32'h8000_0000, 1, KIND_FINITE));
		directed.push_back(make_req(OP_MUL, 32'h7fff_ffff, 32'h8000_0000, KIND_FINITE,
			32'h8000_0000, 32'h7fff_ffff, KIND_FINITE));
		directed.push_back(make_req(OP_DIV, 3, 5, KIND_FINITE, 0, 9, KIND_FINITE));
		directed.push_back(make_req(OP_DIV, 3, 5, KIND_FINITE, 7, 0, KIND_FINITE));
		directed.push_back(make_req(OP_DIV, -3, 5, KIND_FINITE, 6, -7, KIND_FINITE));
		directed.push_back(make_req(OP_EQ, 0, 0, KIND_MAX, 5, 5, KIND_MAX));
		directed.push_back(make_req(OP_EQ, 2, -4, KIND_FINITE, -1, 2, KIND_FINITE));
		directed.push_back(make_req(OP_LT, 0, 0, KIND_MIN, 0, 0, KIND_MIN));
		directed.push_back(make_req(OP_LE, 5, 1, KIND_FINITE, 5, 1, KIND_FINITE));
		directed.push_back(make_req(OP_GT, 0, 0, KIND_MAX, 1, 1, KIND_FINITE));
		directed.push_back(make_req(OP_GE, 32'h8000_0000, 1, KIND_FINITE,
			32'h7fff_ffff, 1, KIND_FINITE));
		directed.push_back(make_req(OP_TO_INT, -7, 2, KIND_FINITE, 0, 0, KIND_FINITE));
		directed.push_back(make_req(OP_TO_INT, 5, 0, KIND_FINITE, 0, 0, KIND_FINITE));
		directed.push_back(make_req(OP_TO_INT, 0, 0, KIND_FINITE, 0, 0, KIND_FINITE));
		directed.push_back(make_req(OP_TO_INT, 1, 1, KIND_MIN, 0, 0, KIND_FINITE));
		directed.push_back(make_req(4'd15, 1, 1, KIND_FINITE, 1, 1, KIND_FINITE));

		foreach (directed[i])
			offer(directed[i]);
		repeat (NUM_RANDOM)
			offer(rand_req());
		req_valid <= 0;

		while (sb.expected_rsp.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.expected_rsp.size() != 0)
			sb.report("transactions left without a response");

		if (sb.errors == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
